// ----- design/hsl_pkg.sv -----
// Shared types and fixed-point constants for the HSL to RGB converter.
package hsl_pkg;

    // Pipeline depth, one register stage per entry
    localparam int unsigned NumStages = 6;
    typedef logic [NumStages-1:0] t_stage_en;

    // Hue units: 1/16 degree
    localparam logic [16:0] HueTurn    = 17'd5760;
    localparam logic [12:0] HueSector  = 13'd960;
    // Offset that lifts any signed 16-bit hue (biased by 32768) to a whole number of turns
    localparam logic [16:0] HueBiasAdd = 17'd1792;

    // Reciprocals for divide-by-constant, rounded up so the floor is exact over the range
    localparam int unsigned CShift = 24;   // cn / 255, cn < 2^16
    localparam logic [16:0] CRecip = 17'((64'd1 << CShift) / 64'd255 + 64'd1);
    localparam int unsigned MShift = 27;   // mn / 510, mn < 2^17
    localparam logic [18:0] MRecip = 19'((64'd1 << MShift) / 64'd510 + 64'd1);
    localparam int unsigned XShift = 45;   // xn / 244800, xn < 2^26
    localparam logic [27:0] XRecip = 28'((64'd1 << XShift) / 64'd244800 + 64'd1);

    // 60-degree hue sectors
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    // Values handed from the front half to the back half
    typedef struct packed {
        t_sector     sector;
        logic [15:0] cn;      // d * s
        logic [9:0]  f;       // distance into the sector pair, 0..960
        logic [32:0] c_prod;  // cn * CRecip
        logic [16:0] m_num;   // 510*l - cn
    } t_front_out;

endpackage

// ----- design/hsl_front.sv -----
// Front half: hue wrap, chroma product, sector decode and divide setup (stages 1 to 3).
module hsl_front (
    input  logic                 i_clk,
    input  hsl_pkg::t_stage_en   i_en,
    input  logic [15:0]          i_hue,
    input  logic [7:0]           i_saturation,
    input  logic [7:0]           i_lightness,
    output hsl_pkg::t_front_out  o_front
);

    // Stage 1 registers
    logic [14:0] r1_hue, n1_hue;
    logic [7:0]  r1_d, n1_d;
    logic [7:0]  r1_s;
    logic [7:0]  r1_l;
    // Stage 2 registers
    logic [12:0] r2_hq, n2_hq;
    logic [15:0] r2_cn, n2_cn;
    logic [7:0]  r2_l;
    // Stage 3 registers
    hsl_pkg::t_front_out r3_out, n3_out;

    logic [16:0] hue_biased;
    logic [16:0] step_a;
    logic [14:0] step_b;
    logic [12:0] base;
    logic [12:0] off;
    hsl_pkg::t_sector sec;

    // Stage 1: bias hue to unsigned, first two restoring steps of mod 5760; lightness distance
    always_comb begin
        hue_biased = {~i_hue[15], i_hue[14:0]} + hsl_pkg::HueBiasAdd;
        step_a = (hue_biased >= 17'(hsl_pkg::HueTurn * 17'd8))
            ? hue_biased - 17'(hsl_pkg::HueTurn * 17'd8) : hue_biased;
        n1_hue = (step_a >= 17'(hsl_pkg::HueTurn * 17'd4))
            ? 15'(step_a - 17'(hsl_pkg::HueTurn * 17'd4)) : step_a[14:0];
        if (i_lightness[7]) begin
            n1_d = 8'(9'd510 - {i_lightness, 1'b0});
        end else begin
            n1_d = {i_lightness[6:0], 1'b0};
        end
    end

    // Stage 2: last two restoring steps, chroma numerator
    always_comb begin
        step_b = (r1_hue >= 15'(hsl_pkg::HueTurn * 17'd2))
            ? r1_hue - 15'(hsl_pkg::HueTurn * 17'd2) : r1_hue;
        n2_hq = (step_b >= 15'(hsl_pkg::HueTurn))
            ? 13'(step_b - 15'(hsl_pkg::HueTurn)) : step_b[12:0];
        n2_cn = r1_d * r1_s;
    end

    // Stage 3: sector decode, sector-pair distance, reciprocal multiply for C, m numerator
    always_comb begin
        if (r2_hq >= 13'(hsl_pkg::HueSector * 13'd5)) begin
            sec = hsl_pkg::SEC_MAG_RED;
        end else if (r2_hq >= 13'(hsl_pkg::HueSector * 13'd4)) begin
            sec = hsl_pkg::SEC_BLU_MAG;
        end else if (r2_hq >= 13'(hsl_pkg::HueSector * 13'd3)) begin
            sec = hsl_pkg::SEC_CYN_BLU;
        end else if (r2_hq >= 13'(hsl_pkg::HueSector * 13'd2)) begin
            sec = hsl_pkg::SEC_GRN_CYN;
        end else if (r2_hq >= hsl_pkg::HueSector) begin
            sec = hsl_pkg::SEC_YEL_GRN;
        end else begin
            sec = hsl_pkg::SEC_RED_YEL;
        end
        base = 13'(hsl_pkg::HueSector * 13'(sec));
        off  = r2_hq - base;
        n3_out.sector = sec;
        // odd sectors run downhill toward the next primary
        n3_out.f      = sec[0] ? 10'(hsl_pkg::HueSector - off) : off[9:0];
        n3_out.cn     = r2_cn;
        n3_out.c_prod = r2_cn * hsl_pkg::CRecip;
        n3_out.m_num  = ({r2_l, 9'd0} - {8'd0, r2_l, 1'b0}) - {1'b0, r2_cn};
    end

    // Stage registers, each held while its stage is stalled
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_hue <= n1_hue;
            r1_d   <= n1_d;
            r1_s   <= i_saturation;
            r1_l   <= i_lightness;
        end
        if (i_en[1]) begin
            r2_hq <= n2_hq;
            r2_cn <= n2_cn;
            r2_l  <= r1_l;
        end
        if (i_en[2]) begin
            r3_out <= n3_out;
        end
    end

    assign o_front = r3_out;

endmodule

// ----- design/hsl_back.sv -----
// Back half: X and m divides by reciprocal, channel ordering and offset add (stages 4 to 6).
module hsl_back (
    input  logic                 i_clk,
    input  hsl_pkg::t_stage_en   i_en,
    input  hsl_pkg::t_front_out  i_front,
    output logic [7:0]           o_red,
    output logic [7:0]           o_green,
    output logic [7:0]           o_blue
);

    // Stage 4 registers
    hsl_pkg::t_sector r4_sector;
    logic [25:0] r4_xn;
    logic [7:0]  r4_c8;
    logic [35:0] r4_m_prod;
    // Stage 5 registers
    hsl_pkg::t_sector r5_sector;
    logic [53:0] r5_x_prod;
    logic [7:0]  r5_c8;
    logic [7:0]  r5_m8;
    // Stage 6 (output) registers
    logic [7:0]  r6_red, n6_red;
    logic [7:0]  r6_green, n6_green;
    logic [7:0]  r6_blue, n6_blue;

    logic [7:0] x8;

    // Stage 6: place C and X by sector, add the offset
    always_comb begin
        x8 = r5_x_prod[hsl_pkg::XShift +: 8];
        case (r5_sector)
            hsl_pkg::SEC_RED_YEL: begin
                n6_red = r5_c8; n6_green = x8;    n6_blue = 8'd0;
            end
            hsl_pkg::SEC_YEL_GRN: begin
                n6_red = x8;    n6_green = r5_c8; n6_blue = 8'd0;
            end
            hsl_pkg::SEC_GRN_CYN: begin
                n6_red = 8'd0;  n6_green = r5_c8; n6_blue = x8;
            end
            hsl_pkg::SEC_CYN_BLU: begin
                n6_red = 8'd0;  n6_green = x8;    n6_blue = r5_c8;
            end
            hsl_pkg::SEC_BLU_MAG: begin
                n6_red = x8;    n6_green = 8'd0;  n6_blue = r5_c8;
            end
            default: begin
                n6_red = r5_c8; n6_green = 8'd0;  n6_blue = x8;
            end
        endcase
        n6_red   = n6_red + r5_m8;
        n6_green = n6_green + r5_m8;
        n6_blue  = n6_blue + r5_m8;
    end

    // Stage registers
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_sector <= i_front.sector;
            r4_xn     <= i_front.cn * i_front.f;
            r4_c8     <= i_front.c_prod[hsl_pkg::CShift +: 8];
            r4_m_prod <= i_front.m_num * hsl_pkg::MRecip;
        end
        if (i_en[4]) begin
            r5_sector <= r4_sector;
            r5_x_prod <= r4_xn * hsl_pkg::XRecip;
            r5_c8     <= r4_c8;
            r5_m8     <= r4_m_prod[hsl_pkg::MShift +: 8];
        end
        if (i_en[5]) begin
            r6_red   <= n6_red;
            r6_green <= n6_green;
            r6_blue  <= n6_blue;
        end
    end

    assign o_red   = r6_red;
    assign o_green = r6_green;
    assign o_blue  = r6_blue;

endmodule

// ----- design/hsl_to_rgb_converter.sv -----
// Top level of the HSL to RGB converter: stream ports and pipeline flow control.
//
// Usage:
//   Slave stream s_axis_* takes one HSL color per item; master stream m_axis_*
//   returns one RGB color, 8 bits per channel, per item, in the same order.
//   Hue is signed 1/16 degree and wraps by any number of turns; saturation and
//   lightness are 8-bit fractions with 255 as 1.0.
//   When nothing stalls, an accepted item passes the six register stages in order;
//   m_axis_tvalid rises when it reaches the last. Throughput is one item per cycle
//   while the receiver keeps m_axis_tready high: each item moves one stage per
//   cycle, and no state links one item to the next.
//   Every stage carries a valid bit and moves when the stage after it is empty
//   or moving, so bubbles close up. When the receiver holds m_axis_tready low,
//   the output item stays put and s_axis_tready stays high until all six stages
//   are full, then drops; nothing is lost or repeated.
//   Synchronous active-low reset clears all valid bits; the block accepts items
//   as soon as reset is released.
module hsl_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // hue[15:0], saturation[23:16], lightness[31:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int unsigned Last = hsl_pkg::NumStages - 1;

    hsl_pkg::t_stage_en  r_valid, n_valid;
    hsl_pkg::t_stage_en  en;
    hsl_pkg::t_front_out front;
    logic [7:0] red, green, blue;

    // Stage enables: a stage loads when it is empty or its content moves on
    always_comb begin
        en[Last] = !r_valid[Last] || m_axis_tready;
        for (int k = Last - 1; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k + 1];
        end
        n_valid = r_valid;
        if (en[0]) begin
            n_valid[0] = s_axis_tvalid;
        end
        for (int k = 1; k <= Last; k++) begin
            if (en[k]) begin
                n_valid[k] = r_valid[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    hsl_front u_front (
        .i_clk        (i_clk),
        .i_en         (en),
        .i_hue        (s_axis_tdata[15:0]),
        .i_saturation (s_axis_tdata[23:16]),
        .i_lightness  (s_axis_tdata[31:24]),
        .o_front      (front)
    );

    hsl_back u_back (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_front (front),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = r_valid[Last];
    assign m_axis_tdata  = {blue, green, red};

endmodule

// ----- design/hsl_checker.sv -----
// Port-level checks for the HSL to RGB converter, bound to the top level.
module hsl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // An empty output stage means the whole pipe can move, so input is ready
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while output stage empty");

    // A stalled output item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed under stall");

    // With the receiver ready throughout, an accepted item reaches the output stage
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
        ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid)
        else $error("item did not reach the output in six cycles");

endmodule

bind hsl_to_rgb_converter hsl_checker u_hsl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/tb_hsl_to_rgb_converter.sv -----
// Self-checking testbench for the HSL to RGB converter: directed and random colors under flow control.
module tb_hsl_to_rgb_converter;

    // Fixed-point hue units: 1/16 degree
    localparam int TurnSteps   = 5760;
    localparam int SectorSteps = 960;
    localparam int FullScale   = 255;

    // Red in the lowest byte, as on m_axis_tdata
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // hue[15:0], saturation[23:16], lightness[31:24]
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [23:0] m_axis_tdata;       // red[7:0], green[15:8], blue[23:16]

    t_rgb expected_rgb[$];
    int   error_count = 0;
    int   send_idle_pct = 25;
    int   recv_stall_pct = 72;

    hsl_to_rgb_converter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected color for one HSL item, exact integer arithmetic with floor division
    function automatic t_rgb predict_rgb(logic signed [15:0] hue, logic [7:0] sat,
                                         logic [7:0] light);
        int hq, two_l, chroma_num, t, f, c8, x8, m8;
        int chan [3];
        hsl_pkg::t_sector sector;
        t_rgb rgb;
        hq = int'(hue) % TurnSteps;
        if (hq < 0) hq += TurnSteps;
        two_l = 2 * int'(light) - FullScale;
        if (two_l < 0) two_l = -two_l;
        chroma_num = (FullScale - two_l) * int'(sat);
        t = hq % (2 * SectorSteps);
        f = (t >= SectorSteps) ? (2 * SectorSteps - t) : t;
        c8 = chroma_num / FullScale;
        x8 = (chroma_num * f) / (FullScale * SectorSteps);
        m8 = (2 * FullScale * int'(light) - chroma_num) / (2 * FullScale);
        sector = hsl_pkg::t_sector'(hq / SectorSteps);
        case (sector)
            hsl_pkg::SEC_RED_YEL: chan = '{c8, x8, 0};
            hsl_pkg::SEC_YEL_GRN: chan = '{x8, c8, 0};
            hsl_pkg::SEC_GRN_CYN: chan = '{0, c8, x8};
            hsl_pkg::SEC_CYN_BLU: chan = '{0, x8, c8};
            hsl_pkg::SEC_BLU_MAG: chan = '{x8, 0, c8};
            default:              chan = '{c8, 0, x8};
        endcase
        rgb.red   = 8'(chan[0] + m8);
        rgb.green = 8'(chan[1] + m8);
        rgb.blue  = 8'(chan[2] + m8);
        return rgb;
    endfunction

    function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Send one item; random idle cycles in front, hold until accepted
    task automatic send_color(logic signed [15:0] hue, logic [7:0] sat, logic [7:0] light);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {light, sat, hue};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_rgb.push_back(predict_rgb(hue, sat, light));
    endtask

    // Result check and receiver stalls
    always @(posedge i_clk) begin : rgb_check
        t_rgb want;
        t_rgb got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (expected_rgb.size() == 0) begin
                $error("unexpected result: red %0d green %0d blue %0d",
                       got.red, got.green, got.blue);
                error_count++;
            end else begin
                want = expected_rgb.pop_front();
                check_channel("red", want.red, got.red);
                check_channel("green", want.green, got.green);
                check_channel("blue", want.blue, got.blue);
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Mostly random levels, with the ends of the range weighted up
    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_field_extremes();
        send_color(16'sd0, 8'd255, 8'd255);
        send_color(16'sd0, 8'd255, 8'd0);
        send_color(16'sd0, 8'd255, 8'd127);
        send_color(16'sd0, 8'd255, 8'd128);
        send_color(16'sh7FFF, 8'd255, 8'd128);
        send_color(-16'sd32768, 8'd255, 8'd128);
    endtask

    task automatic test_negative_hue();
        send_color(-16'sd1, 8'd255, 8'd128);
        send_color(-16'sd16, 8'd200, 8'd100);
        send_color(-16'sd960, 8'd255, 8'd128);
        send_color(-16'sd5760, 8'd255, 8'd128);
    endtask

    // Exact multiples of 60 degrees from 60 to 360, and one step below each but 360
    task automatic test_sector_bounds();
        for (int k = 1; k <= 5; k++) begin
            send_color(16'(k * SectorSteps - 1), 8'd255, 8'd128);
            send_color(16'(k * SectorSteps), 8'd255, 8'd128);
        end
        send_color(16'(TurnSteps), 8'd255, 8'd128);
    endtask

    task automatic test_zero_saturation();
        send_color(16'sd1234, 8'd0, 8'd77);
        send_color(-16'sd3000, 8'd0, 8'd255);
        send_color(16'sd0, 8'd0, 8'd0);
    endtask

    task automatic test_random_colors(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) begin
            send_color(16'($urandom_range(0, 65535)), pick_level(), pick_level());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_negative_hue();
        test_sector_bounds();
        test_zero_saturation();
        test_random_colors(700, 25, 72);
        test_random_colors(700, 72, 25);
        test_random_colors(600, 0, 0);
        s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline run dry
        while (expected_rgb.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_hsl_to_rgb_converter: PASS");
        end else begin
            $display("tb_hsl_to_rgb_converter: FAIL");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("tb_hsl_to_rgb_converter: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/hsl_pkg.sv
design/hsl_front.sv
design/hsl_back.sv
design/hsl_to_rgb_converter.sv
design/hsl_checker.sv
tb/tb_hsl_to_rgb_converter.sv
